// ===== hw/rtl/pwmsch_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmsch_pkg
// Shared types and constants for the three-channel PWM edge scheduler.
// ----------------------------------------------------------------------------
package pwmsch_pkg;

  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned SCHED_SLOTS = 4;
  localparam int unsigned SLOT_W      = $clog2(SCHED_SLOTS);
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned TIME_W      = 8;
  localparam int unsigned PORT_W      = 8;

  // Q2.14 full scale (1.0)
  localparam int unsigned FULL_SCALE    = 16384;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 8'd253;
  localparam logic [PORT_W-1:0]  ALL_HIGH      = 8'hFF;
  localparam logic [PORT_W-1:0]  PIN_NONE      = 8'h00;
  localparam logic [SLOT_W-1:0]  SLOT_FIRST    = 2'd0;
  localparam logic [SLOT_W-1:0]  SLOT_LAST     = 2'd3;

  // Motor pin masks: motor one on port D, motor two on port B,
  // motor three split between D (forward) and B (reverse).
  localparam logic [PORT_W-1:0] M1_FWD_D = 8'b0010_0000;
  localparam logic [PORT_W-1:0] M1_REV_D = 8'b0100_0000;
  localparam logic [PORT_W-1:0] M2_FWD_B = 8'b0000_0010;
  localparam logic [PORT_W-1:0] M2_REV_B = 8'b0000_0100;
  localparam logic [PORT_W-1:0] M3_FWD_D = 8'b0000_1000;
  localparam logic [PORT_W-1:0] M3_REV_B = 8'b0000_0001;

  // Per-channel off time and the pin it drives low
  typedef struct packed {
    logic [NUM_CH-1:0][TIME_W-1:0] off;
    logic [NUM_CH-1:0][PORT_W-1:0] pin_b;
    logic [NUM_CH-1:0][PORT_W-1:0] pin_d;
  } chan_t;

  // One schedule entry
  typedef struct packed {
    logic [TIME_W-1:0] cmp_time;
    logic [PORT_W-1:0] lvl_b;
    logic [PORT_W-1:0] lvl_d;
  } entry_t;

  // Slots 1..3 of a schedule (slot 0 is constant); index is slot - 1
  typedef entry_t [SCHED_SLOTS-2:0] sched_t;

endpackage

// ===== hw/rtl/pwmsch_off_stage.sv =====
// ----------------------------------------------------------------------------
// pwmsch_off_stage
// Input register, then off time and pin selection per motor into a
// channel register.
// ----------------------------------------------------------------------------
module pwmsch_off_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [3*pwmsch_pkg::SPEED_W-1:0]    in_tdata,
  input  logic [pwmsch_pkg::LEVEL_W-1:0]      max_level,
  output logic                                chan_valid,
  input  logic                                chan_ready,
  output pwmsch_pkg::chan_t                   chan
);

  logic                                              in_valid_r;
  logic [pwmsch_pkg::NUM_CH-1:0][pwmsch_pkg::SPEED_W-1:0] speed_r;
  logic                                              chan_valid_r;
  pwmsch_pkg::chan_t                                 chan_r;
  pwmsch_pkg::chan_t                                 chan_nxt;
  logic                                              adv;

  // Off time: 255 - ceil(min(|speed|, 1.0) * level / 16384)
  function automatic logic [pwmsch_pkg::TIME_W-1:0] off_time(
    input logic [pwmsch_pkg::SPEED_W-1:0] spd,
    input logic [pwmsch_pkg::LEVEL_W-1:0] lvl
  );
    logic [16:0] mag;
    logic [14:0] clp;
    logic [22:0] prod;
    logic [23:0] sum;
    mag  = spd[15] ? (17'd0 - {spd[15], spd}) : {1'b0, spd};
    clp  = (mag > 17'(pwmsch_pkg::FULL_SCALE)) ? 15'(pwmsch_pkg::FULL_SCALE)
                                                : mag[14:0];
    prod = 23'(clp) * 23'(lvl);
    sum  = {1'b0, prod} + 24'(pwmsch_pkg::FULL_SCALE - 1);
    return 8'd255 - sum[21:14];
  endfunction

  // Advance the input item when the channel register is free
  assign adv       = in_valid_r && (!chan_valid_r || chan_ready);
  assign in_tready = !in_valid_r || adv;

  // Compute off times and pin masks
  always_comb begin
    logic [pwmsch_pkg::NUM_CH-1:0] fwd;
    for (int c = 0; c < pwmsch_pkg::NUM_CH; c++) begin
      fwd[c]          = (speed_r[c] != '0) && !speed_r[c][15];
      chan_nxt.off[c] = off_time(speed_r[c], max_level);
    end
    chan_nxt.pin_d[0] = fwd[0] ? pwmsch_pkg::M1_FWD_D : pwmsch_pkg::M1_REV_D;
    chan_nxt.pin_b[0] = pwmsch_pkg::PIN_NONE;
    chan_nxt.pin_d[1] = pwmsch_pkg::PIN_NONE;
    chan_nxt.pin_b[1] = fwd[1] ? pwmsch_pkg::M2_FWD_B : pwmsch_pkg::M2_REV_B;
    chan_nxt.pin_d[2] = fwd[2] ? pwmsch_pkg::M3_FWD_D : pwmsch_pkg::PIN_NONE;
    chan_nxt.pin_b[2] = fwd[2] ? pwmsch_pkg::PIN_NONE : pwmsch_pkg::M3_REV_B;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      speed_r <= in_tdata;
    end
  end

  // Channel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_valid_r <= 1'b0;
    end else if (!chan_valid_r || chan_ready) begin
      chan_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan_valid = chan_valid_r;
  assign chan       = chan_r;

endmodule

// ===== hw/rtl/pwmsch_sort.sv =====
// ----------------------------------------------------------------------------
// pwmsch_sort
// Rank and merge the three off times and build schedule slots 1..3.
// ----------------------------------------------------------------------------
module pwmsch_sort (
  input  pwmsch_pkg::chan_t  chan,
  output pwmsch_pkg::sched_t sched
);

  logic [pwmsch_pkg::NUM_CH-1:0] uniq;
  logic [1:0]                    n_dist;

  // Mark the first channel of each distinct off time
  always_comb begin
    uniq[0] = 1'b1;
    uniq[1] = chan.off[1] != chan.off[0];
    uniq[2] = (chan.off[2] != chan.off[0]) && (chan.off[2] != chan.off[1]);
    n_dist  = 2'(uniq[0]) + 2'(uniq[1]) + 2'(uniq[2]);
  end

  // Place each distinct time at its rank, dummies fill the leading slots
  always_comb begin
    logic [1:0]                   rank;
    logic [1:0]                   idx;
    logic [pwmsch_pkg::PORT_W-1:0] clr_b;
    logic [pwmsch_pkg::PORT_W-1:0] clr_d;
    for (int i = 0; i < pwmsch_pkg::SCHED_SLOTS - 1; i++) begin
      sched[i].cmp_time = pwmsch_pkg::TIME_W'(i + 1);
      sched[i].lvl_b    = pwmsch_pkg::ALL_HIGH;
      sched[i].lvl_d    = pwmsch_pkg::ALL_HIGH;
    end
    for (int c = 0; c < pwmsch_pkg::NUM_CH; c++) begin
      rank  = 2'd0;
      clr_b = pwmsch_pkg::PIN_NONE;
      clr_d = pwmsch_pkg::PIN_NONE;
      for (int d = 0; d < pwmsch_pkg::NUM_CH; d++) begin
        if (uniq[d] && (chan.off[d] < chan.off[c])) begin
          rank = rank + 2'd1;
        end
        if (chan.off[d] <= chan.off[c]) begin
          clr_b = clr_b | chan.pin_b[d];
          clr_d = clr_d | chan.pin_d[d];
        end
      end
      idx = 2'd3 - n_dist + rank;
      if (uniq[c]) begin
        sched[idx].cmp_time = chan.off[c];
        sched[idx].lvl_b    = pwmsch_pkg::ALL_HIGH & ~clr_b;
        sched[idx].lvl_d    = pwmsch_pkg::ALL_HIGH & ~clr_d;
      end
    end
  end

endmodule

// ===== hw/rtl/pwmsch_emit.sv =====
// ----------------------------------------------------------------------------
// pwmsch_emit
// Schedule register and slot counter; sends the four entries in order.
// ----------------------------------------------------------------------------
module pwmsch_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sched_valid,
  output logic               sched_ready,
  input  pwmsch_pkg::sched_t sched,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic               out_tlast
);

  logic                               sched_valid_r;
  pwmsch_pkg::sched_t                 sched_r;
  logic [pwmsch_pkg::SLOT_W-1:0]      slot_r;
  logic [pwmsch_pkg::SLOT_W-1:0]      slot_nxt;
  logic                               out_fire;
  logic                               last_fire;
  pwmsch_pkg::entry_t                 cur;

  assign out_fire    = out_tvalid && out_tready;
  assign last_fire   = out_fire && (slot_r == pwmsch_pkg::SLOT_LAST);
  assign sched_ready = !sched_valid_r || last_fire;
  assign slot_nxt    = last_fire ? pwmsch_pkg::SLOT_FIRST : slot_r + 2'd1;

  // Hold the schedule until its last entry leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_valid_r <= 1'b0;
    end else if (sched_ready) begin
      sched_valid_r <= sched_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sched_valid && sched_ready) begin
      sched_r <= sched;
    end
  end

  // Advance the slot on each accepted entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= pwmsch_pkg::SLOT_FIRST;
    end else if (out_fire) begin
      slot_r <= slot_nxt;
    end
  end

  // Select the current entry; slot 0 is time 0 with all pins high
  always_comb begin
    case (slot_r)
      2'd0: begin
        cur.cmp_time = '0;
        cur.lvl_b    = pwmsch_pkg::ALL_HIGH;
        cur.lvl_d    = pwmsch_pkg::ALL_HIGH;
      end
      2'd1:    cur = sched_r[0];
      2'd2:    cur = sched_r[1];
      default: cur = sched_r[2];
    endcase
  end

  assign out_tvalid = sched_valid_r;
  assign out_tlast  = slot_r == pwmsch_pkg::SLOT_LAST;
  assign out_tdata  = {6'd0, cur.lvl_d, cur.lvl_b, cur.cmp_time, slot_r};

  // Counter rests at slot 0 while no schedule is held
  a_idle_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    !sched_valid_r |-> slot_r == pwmsch_pkg::SLOT_FIRST)
    else $error("slot counter not at zero while idle");

  // A non-final entry keeps the schedule and moves to the next slot
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && (slot_r != pwmsch_pkg::SLOT_LAST)
      |=> sched_valid_r && (slot_r == $past(slot_r) + 2'd1))
    else $error("schedule lost or slot skipped mid-run");

  // A stalled entry keeps its slot and its schedule
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(slot_r) && $stable(sched_r))
    else $error("entry changed under stall");

endmodule

// ===== hw/rtl/three_channel_pwm_edge_scheduler.sv =====
// Pipeline: input register, channel register after the off-time multipliers, and
//   schedule register after the sort; slot 0 is offered once the item reaches the
//   schedule register.
// Output: the four entries leave the schedule register one per cycle while
//   out_tready is high; the next item is taken meanwhile.
// Reset (rst_n low, synchronous): pipeline empties, max_level returns to 253.
// ----------------------------------------------------------------------------
// three_channel_pwm_edge_scheduler
// Turns three signed motor speeds into a sorted four-entry PWM edge schedule.
// ----------------------------------------------------------------------------
module three_channel_pwm_edge_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // max_level
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,      // speed_a[15:0], speed_b[31:16], speed_c[47:32]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // slot[1:0], compare_time[9:2],
                                     // port_b_level[17:10], port_d_level[25:18], zeros
  output logic        out_tlast      // last_entry
);

  logic [pwmsch_pkg::LEVEL_W-1:0] max_level_r;
  logic                           chan_valid;
  logic                           chan_ready;
  pwmsch_pkg::chan_t              chan;
  pwmsch_pkg::sched_t             sched;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r <= pwmsch_pkg::MAX_LEVEL_RST;
    end else if (cfg_wr_en) begin
      max_level_r <= cfg_wr_data;
    end
  end

  pwmsch_off_stage u_off (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .max_level  (max_level_r),
    .chan_valid (chan_valid),
    .chan_ready (chan_ready),
    .chan       (chan)
  );

  pwmsch_sort u_sort (
    .chan  (chan),
    .sched (sched)
  );

  pwmsch_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .sched_valid (chan_valid),
    .sched_ready (chan_ready),
    .sched       (sched),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-channel PWM edge scheduler: drives speed
// triples under several max_level settings, predicts every schedule entry
// and compares each entry on the result stream, with random gaps on both
// sides of the handshake.
// ----------------------------------------------------------------------------
module tb_top;
  import pwmsch_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] cmp;
    logic [PORT_W-1:0] lvl_b;
    logic [PORT_W-1:0] lvl_d;
    logic              last;
  } sched_entry_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;     // speed_a[15:0], speed_b[31:16], speed_c[47:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // slot[1:0], compare_time[9:2],
                                  // port_b_level[17:10], port_d_level[25:18], zeros
  logic        out_tlast;         // last_entry

  logic [47:0]       speed_items[$];
  sched_entry_t      sched_due[$];
  logic [LEVEL_W-1:0] level_model = MAX_LEVEL_RST;
  bit                no_gaps = 1'b0;
  int                fails = 0;
  int                items_taken = 0;
  int                entries_seen = 0;
  int                levels_used = 1;

  three_channel_pwm_edge_scheduler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the four schedule entries for one speed triple
  function automatic void plan_schedule(input logic [47:0] word,
                                        input logic [LEVEL_W-1:0] lvl);
    logic [SPEED_W-1:0] spd;
    int unsigned        mag;
    int unsigned        up;
    logic [TIME_W-1:0]  off[NUM_CH];
    logic [PORT_W-1:0]  pin_b[NUM_CH];
    logic [PORT_W-1:0]  pin_d[NUM_CH];
    logic [TIME_W-1:0]  edge_t[NUM_CH];
    logic [PORT_W-1:0]  edge_b[NUM_CH];
    logic [PORT_W-1:0]  edge_d[NUM_CH];
    bit                 done[NUM_CH];
    bit                 fwd;
    logic [TIME_W-1:0]  lo;
    logic [PORT_W-1:0]  cur_b;
    logic [PORT_W-1:0]  cur_d;
    int                 n;
    int                 handled;
    int                 first_slot;
    int                 j;
    sched_entry_t       e;

    // Off time and active pin per motor
    for (int c = 0; c < NUM_CH; c++) begin
      spd = word[SPEED_W*c +: SPEED_W];
      mag = spd[SPEED_W-1] ? 32'h10000 - spd : spd;
      if (mag > FULL_SCALE) mag = FULL_SCALE;
      up = (mag * lvl + FULL_SCALE - 1) / FULL_SCALE;
      off[c] = TIME_W'(255 - up);
      fwd = (spd != '0) && !spd[SPEED_W-1];
      pin_b[c] = PIN_NONE;
      pin_d[c] = PIN_NONE;
      done[c] = 1'b0;
      case (c)
        0: begin
          pin_d[c] = fwd ? M1_FWD_D : M1_REV_D;
        end
        1: begin
          pin_b[c] = fwd ? M2_FWD_B : M2_REV_B;
        end
        default: begin
          if (fwd) pin_d[c] = M3_FWD_D;
          else pin_b[c] = M3_REV_B;
        end
      endcase
    end

    // Sort the off times, merging equal ones into one edge
    n = 0;
    handled = 0;
    cur_b = ALL_HIGH;
    cur_d = ALL_HIGH;
    while (handled < NUM_CH) begin
      lo = '1;
      for (int c = 0; c < NUM_CH; c++)
        if (!done[c] && off[c] <= lo) lo = off[c];
      for (int c = 0; c < NUM_CH; c++) begin
        if (!done[c] && off[c] == lo) begin
          done[c] = 1'b1;
          handled++;
          cur_b &= ~pin_b[c];
          cur_d &= ~pin_d[c];
        end
      end
      edge_t[n] = lo;
      edge_b[n] = cur_b;
      edge_d[n] = cur_d;
      n++;
    end

    // Slot 0, leading dummies, then the edges packed at the end
    first_slot = SCHED_SLOTS - n;
    for (int k = 0; k < SCHED_SLOTS; k++) begin
      e.slot  = SLOT_W'(k);
      e.last  = (SLOT_W'(k) == SLOT_LAST);
      e.lvl_b = ALL_HIGH;
      e.lvl_d = ALL_HIGH;
      if (k == 0) begin
        e.cmp = '0;
      end else if (k < first_slot) begin
        e.cmp = TIME_W'(k);
      end else begin
        j = k - first_slot;
        e.cmp   = edge_t[j];
        e.lvl_b = edge_b[j];
        e.lvl_d = edge_d[j];
      end
      sched_due.push_back(e);
    end
  endfunction

  // Pick one speed, biased toward the saturation and zero corners
  function automatic logic [SPEED_W-1:0] random_speed();
    int unsigned v;
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h8000;
      4: return 16'h7FFF;
      5: return SPEED_W'($urandom_range(FULL_SCALE));
      6: begin
        v = $urandom_range(FULL_SCALE);
        return SPEED_W'(0 - v);
      end
      7: return SPEED_W'(FULL_SCALE - 64 + $urandom_range(128));
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  // Build a speed triple, often with tied magnitudes
  function automatic logic [47:0] make_item();
    logic [SPEED_W-1:0] s[NUM_CH];
    for (int c = 0; c < NUM_CH; c++) s[c] = random_speed();
    case ($urandom_range(3))
      0: s[1] = s[0];
      1: s[2] = SPEED_W'(0 - s[0]);
      default: ;
    endcase
    return {s[2], s[1], s[0]};
  endfunction

  // Input driver: hold each item until taken, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        plan_schedule(in_tdata, level_model);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (speed_items.size() != 0 && (no_gaps || $urandom_range(99) >= 37)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= speed_items.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each entry with the oldest prediction
  always @(posedge clk) begin : entry_check
    sched_entry_t got;
    sched_entry_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[9:2], out_tdata[17:10], out_tdata[25:18],
               out_tlast};
        entries_seen++;
        if (sched_due.size() == 0) begin
          $display("%0t: unexpected entry slot %0d time %0d B %02h D %02h last %0b",
                   $time, got.slot, got.cmp, got.lvl_b, got.lvl_d, got.last);
          fails++;
        end else begin
          want = sched_due.pop_front();
          if (got.slot !== want.slot || got.cmp !== want.cmp || got.lvl_b !== want.lvl_b ||
              got.lvl_d !== want.lvl_d || got.last !== want.last) begin
            $display("%0t: entry mismatch: expected slot %0d time %0d B %02h D %02h last %0b",
                     $time, want.slot, want.cmp, want.lvl_b, want.lvl_d, want.last);
            $display("%0t:                 actual   slot %0d time %0d B %02h D %02h last %0b",
                     $time, got.slot, got.cmp, got.lvl_b, got.lvl_d, got.last);
            fails++;
          end
        end
      end
      out_tready <= no_gaps || $urandom_range(99) >= 37;
    end
  end

  // Wait until the pipeline holds nothing that is still owed
  task automatic wait_drained();
    do @(negedge clk);
    while (speed_items.size() != 0 || in_tvalid || sched_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Write max_level while the block is idle
  task automatic set_level(input logic [LEVEL_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    level_model = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    levels_used++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [LEVEL_W-1:0] levels[8];
    levels = '{8'd255, 8'd0, 8'd254, 8'd1, 8'd128, 8'($urandom_range(255)),
               MAX_LEVEL_RST, 8'($urandom_range(252, 2))};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed triples at the reset level: ties, signs, saturation, tiny values
    speed_items.push_back({16'h0000, 16'h0000, 16'h0000});
    speed_items.push_back({16'h4000, 16'h4000, 16'h4000});
    speed_items.push_back({16'hC000, 16'hC000, 16'hC000});
    speed_items.push_back({16'h4000, 16'h7FFF, 16'h8000});
    speed_items.push_back({16'h0000, 16'hFFFF, 16'h0001});
    speed_items.push_back({16'h1000, 16'h2000, 16'h4000});
    speed_items.push_back({16'h4000, 16'h2000, 16'h1000});
    speed_items.push_back({16'hF000, 16'h2000, 16'hE000});
    speed_items.push_back({16'h1000, 16'h2000, 16'h2000});
    speed_items.push_back({16'hE000, 16'hE000, 16'h1000});
    speed_items.push_back({16'h8001, 16'h0001, 16'h7FFF});
    speed_items.push_back({16'hC001, 16'h4001, 16'h3FFF});
    speed_items.push_back({16'h0000, 16'hFFC0, 16'h0040});
    wait_drained();

    // One phase per level; the sender stops until all entries are back
    foreach (levels[p]) begin
      set_level(levels[p]);
      no_gaps = (p == 3);
      speed_items.push_back({16'h0000, 16'hC000, 16'h4000});
      speed_items.push_back({16'h8000, 16'h8000, 16'h8000});
      repeat (55) speed_items.push_back(make_item());
      wait_drained();
    end
    no_gaps = 1'b0;

    $display("Covered %0d speed triples and %0d schedule entries over %0d max_level settings.",
             items_taken, entries_seen, levels_used);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
